// File: rtl/core/maie_pkg.sv
// Shared types, opcode and function codes for the MIPS ALU execute pipeline.
package maie_pkg;

    // Primary opcodes
    localparam logic [5:0] OPC_RTYPE = 6'h00;
    localparam logic [5:0] OPC_ADDI  = 6'h08;
    localparam logic [5:0] OPC_ADDIU = 6'h09;
    localparam logic [5:0] OPC_ANDI  = 6'h0C;
    localparam logic [5:0] OPC_ORI   = 6'h0D;
    localparam logic [5:0] OPC_XORI  = 6'h0E;
    localparam logic [5:0] OPC_LUI   = 6'h0F;
    localparam logic [5:0] OPC_LW    = 6'h23;
    localparam logic [5:0] OPC_SW    = 6'h2B;

    // R-type function codes
    localparam logic [5:0] FN_SLL  = 6'h00;
    localparam logic [5:0] FN_SRL  = 6'h02;
    localparam logic [5:0] FN_SRA  = 6'h03;
    localparam logic [5:0] FN_ADD  = 6'h20;
    localparam logic [5:0] FN_ADDU = 6'h21;
    localparam logic [5:0] FN_SUB  = 6'h22;
    localparam logic [5:0] FN_SUBU = 6'h23;
    localparam logic [5:0] FN_AND  = 6'h24;
    localparam logic [5:0] FN_OR   = 6'h25;
    localparam logic [5:0] FN_XOR  = 6'h26;
    localparam logic [5:0] FN_NOR  = 6'h27;
    localparam logic [5:0] FN_SLT  = 6'h2A;
    localparam logic [5:0] FN_SLTU = 6'h2B;

    typedef enum logic [3:0] {
        ALU_NONE,
        ALU_ADD,
        ALU_SUB,
        ALU_AND,
        ALU_OR,
        ALU_XOR,
        ALU_NOR,
        ALU_SLT,
        ALU_SLTU,
        ALU_SLL,
        ALU_SRL,
        ALU_SRA,
        ALU_PASSB
    } alu_op_t;

    typedef enum logic [1:0] {
        MEM_NONE  = 2'd0,
        MEM_LOAD  = 2'd1,
        MEM_STORE = 2'd2
    } mem_op_t;

    // Input item
    typedef struct packed {
        logic [31:0]        instruction;
        logic signed [31:0] rs_value;
        logic signed [31:0] rt_value;
    } maie_in_t;

    // Result item
    typedef struct packed {
        logic signed [31:0] result;
        logic [4:0]         dest_num;
        logic               write_enable;
        logic [1:0]         mem_access;
    } maie_out_t;

    // Decode to ALU stage
    typedef struct packed {
        alu_op_t     op;
        logic [31:0] a;
        logic [31:0] b;
        logic [4:0]  shamt;
        logic [4:0]  dest;
        logic        wen;
        mem_op_t     mem;
    } maie_dec_t;

    // ALU to result stage
    typedef struct packed {
        alu_op_t     op;
        logic [32:0] sum;
        logic [31:0] logic_res;
        logic [31:0] shift_res;
        logic        a_msb;
        logic        b_msb;
        logic [4:0]  dest;
        logic        wen;
        mem_op_t     mem;
    } maie_exe_t;

endpackage

// File: rtl/core/maie_decode.sv
// Stage 1: instruction decode and operand selection.
module maie_decode (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  maie_pkg::maie_in_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output maie_pkg::maie_dec_t out_data
);
    import maie_pkg::*;

    logic      valid_reg;
    maie_dec_t data_reg;
    maie_dec_t data_next;

    logic [5:0]  opc;
    logic [5:0]  fn;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic [15:0] imm;
    logic [31:0] imm_sext;
    logic [31:0] imm_zext;
    logic        writes;

    assign opc      = in_data.instruction[31:26];
    assign rt       = in_data.instruction[20:16];
    assign rd       = in_data.instruction[15:11];
    assign fn       = in_data.instruction[5:0];
    assign imm      = in_data.instruction[15:0];
    assign imm_sext = {{16{imm[15]}}, imm};
    assign imm_zext = {16'h0000, imm};

    // Decode the item into an ALU op and operands
    always_comb begin
        data_next.op    = ALU_NONE;
        data_next.a     = 32'(in_data.rs_value);
        data_next.b     = 32'(in_data.rt_value);
        data_next.shamt = in_data.instruction[10:6];
        data_next.dest  = rt;
        data_next.mem   = MEM_NONE;
        writes          = 1'b1;
        if (opc == OPC_RTYPE) begin
            data_next.dest = rd;
            unique case (fn)
                FN_ADD, FN_ADDU: data_next.op = ALU_ADD;
                FN_SUB, FN_SUBU: data_next.op = ALU_SUB;
                FN_AND:          data_next.op = ALU_AND;
                FN_OR:           data_next.op = ALU_OR;
                FN_XOR:          data_next.op = ALU_XOR;
                FN_NOR:          data_next.op = ALU_NOR;
                FN_SLT:          data_next.op = ALU_SLT;
                FN_SLTU:         data_next.op = ALU_SLTU;
                FN_SLL:          data_next.op = ALU_SLL;
                FN_SRL:          data_next.op = ALU_SRL;
                FN_SRA:          data_next.op = ALU_SRA;
                default:         writes       = 1'b0;
            endcase
        end else begin
            unique case (opc)
                OPC_ADDI, OPC_ADDIU: begin
                    data_next.op = ALU_ADD;
                    data_next.b  = imm_sext;
                end
                OPC_ANDI: begin
                    data_next.op = ALU_AND;
                    data_next.b  = imm_zext;
                end
                OPC_ORI: begin
                    data_next.op = ALU_OR;
                    data_next.b  = imm_zext;
                end
                OPC_XORI: begin
                    data_next.op = ALU_XOR;
                    data_next.b  = imm_zext;
                end
                OPC_LUI: begin
                    data_next.op = ALU_PASSB;
                    data_next.b  = {imm, 16'h0000};
                end
                OPC_LW: begin
                    data_next.op  = ALU_ADD;
                    data_next.b   = imm_sext;
                    data_next.mem = MEM_LOAD;
                end
                OPC_SW: begin
                    data_next.op  = ALU_ADD;
                    data_next.b   = imm_sext;
                    data_next.mem = MEM_STORE;
                    writes        = 1'b0;
                end
                default: writes = 1'b0;
            endcase
        end
        // register zero is never written
        data_next.wen = writes && (data_next.dest != 5'd0);
    end

    // Stage register, advances whenever the next stage can take the item
    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// File: rtl/core/maie_alu.sv
// Stage 2: adder, logic unit and barrel shifter working in parallel.
module maie_alu (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  maie_pkg::maie_dec_t in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output maie_pkg::maie_exe_t out_data
);
    import maie_pkg::*;

    logic      valid_reg;
    maie_exe_t data_reg;
    maie_exe_t data_next;
    logic      sub;
    logic [31:0] b_eff;

    // Subtract for SUB and both compares; carry out gives unsigned a >= b
    assign sub   = (in_data.op == ALU_SUB) || (in_data.op == ALU_SLT) ||
                   (in_data.op == ALU_SLTU);
    assign b_eff = sub ? ~in_data.b : in_data.b;

    always_comb begin
        data_next.op    = in_data.op;
        data_next.sum   = {1'b0, in_data.a} + {1'b0, b_eff} + {32'd0, sub};
        data_next.a_msb = in_data.a[31];
        data_next.b_msb = in_data.b[31];
        data_next.dest  = in_data.dest;
        data_next.wen   = in_data.wen;
        data_next.mem   = in_data.mem;

        // Logic unit
        unique case (in_data.op)
            ALU_AND:   data_next.logic_res = in_data.a & in_data.b;
            ALU_OR:    data_next.logic_res = in_data.a | in_data.b;
            ALU_XOR:   data_next.logic_res = in_data.a ^ in_data.b;
            ALU_NOR:   data_next.logic_res = ~(in_data.a | in_data.b);
            ALU_PASSB: data_next.logic_res = in_data.b;
            default:   data_next.logic_res = 32'd0;
        endcase

        // Shifter, distance from shamt
        unique case (in_data.op)
            ALU_SLL: data_next.shift_res = in_data.b << in_data.shamt;
            ALU_SRL: data_next.shift_res = in_data.b >> in_data.shamt;
            ALU_SRA: data_next.shift_res = 32'($signed(in_data.b) >>> in_data.shamt);
            default: data_next.shift_res = 32'd0;
        endcase
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// File: rtl/core/maie_result.sv
// Stage 3: compare resolution, result select and output register.
module maie_result (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  maie_pkg::maie_exe_t in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output maie_pkg::maie_out_t out_data
);
    import maie_pkg::*;

    logic      valid_reg;
    maie_out_t data_reg;
    maie_out_t data_next;
    logic      lt_unsigned;
    logic      lt_signed;

    // No carry out of a + ~b + 1 means a < b unsigned
    assign lt_unsigned = !in_data.sum[32];
    // Signs differ: a is less when negative; otherwise the difference sign decides
    assign lt_signed   = (in_data.a_msb != in_data.b_msb) ? in_data.a_msb
                                                          : in_data.sum[31];

    always_comb begin
        unique case (in_data.op)
            ALU_ADD, ALU_SUB:
                data_next.result = $signed(in_data.sum[31:0]);
            ALU_AND, ALU_OR, ALU_XOR, ALU_NOR, ALU_PASSB:
                data_next.result = $signed(in_data.logic_res);
            ALU_SLT:
                data_next.result = $signed({31'd0, lt_signed});
            ALU_SLTU:
                data_next.result = $signed({31'd0, lt_unsigned});
            ALU_SLL, ALU_SRL, ALU_SRA:
                data_next.result = $signed(in_data.shift_res);
            default:
                data_next.result = 32'sd0;
        endcase
        data_next.dest_num     = in_data.dest;
        data_next.write_enable = in_data.wen;
        data_next.mem_access   = 2'(in_data.mem);
    end

    // Output register doubles as the stall point towards the consumer
    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// File: rtl/core/mips_alu_instruction_execute_top.sv
// Pipeline: three register stages (decode, ALU, result select); an accepted item passes
// through them in that order before it reaches the output.
// Throughput: one item per cycle; each stage holds an item and moves it on when the
// stage after it is empty or being emptied, so a stalled consumer backs items up in place.
// Reset: aresetn is synchronous, active low, and clears the stage valid bits only;
// the stage data registers are not reset.
// Top level of the MIPS32 integer ALU execute pipeline.
module mips_alu_instruction_execute_top (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  maie_pkg::maie_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output maie_pkg::maie_out_t m_data
);
    import maie_pkg::*;

    logic      dec_valid;
    logic      dec_ready;
    maie_dec_t dec_data;
    logic      exe_valid;
    logic      exe_ready;
    maie_exe_t exe_data;

    maie_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .out_valid (dec_valid),
        .out_ready (dec_ready),
        .out_data  (dec_data)
    );

    maie_alu u_alu (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (dec_valid),
        .in_ready  (dec_ready),
        .in_data   (dec_data),
        .out_valid (exe_valid),
        .out_ready (exe_ready),
        .out_data  (exe_data)
    );

    maie_result u_result (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (exe_valid),
        .in_ready  (exe_ready),
        .in_data   (exe_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

    // An accepted item reaches the output when the consumer does not stall it
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) ##1 m_ready ##1 m_ready |=> m_valid)
        else $error("item did not reach the output in three cycles");

    // Register zero is never written
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.write_enable) |-> (m_data.dest_num != 5'd0))
        else $error("write enabled for register zero");

    // A store never writes a register
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.mem_access == 2'(MEM_STORE))) |-> !m_data.write_enable)
        else $error("store item with write enable");

    // The ALU stage can only be blocked when the output register is full
    assert property (@(posedge aclk) disable iff (!aresetn)
        (exe_valid && !exe_ready) |-> (m_valid && !m_ready))
        else $error("ALU stage stalled without output back-pressure");

endmodule
